FILE: hdl/keyframe_channel_sampler_unit_assert.svh
// Assertion helpers shared by the sampler modules.
`ifndef KEYFRAME_CHANNEL_SAMPLER_UNIT_ASSERT_SVH
`define KEYFRAME_CHANNEL_SAMPLER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// The consequent must hold in the cycle after the antecedent.
`define KCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: hdl/kcs_pkg.sv
package kcs_pkg;

  localparam int VAL_W   = 32;          // stored Q value
  localparam int CNT_W   = 13;          // entries_in_use register
  localparam int ADDR_W  = 12;          // write address field
  localparam int FLD_W   = 16;          // start, length, frame fields
  localparam int BLEND_W = 8;           // frames per keyframe
  localparam int IDX_W   = 19;          // signed table index, covers S + L - T + F
  localparam int EXT_W   = VAL_W + 1;   // value after the angle wrap
  localparam int DIF_W   = VAL_W + 2;   // difference of two wrapped values
  localparam int MAG_W   = VAL_W + 1;   // magnitude of that difference
  localparam int PROD_W  = MAG_W + BLEND_W;
  localparam int SUM_W   = PROD_W + 2;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_e;

  // Travels alongside the frame divider.
  typedef struct packed {
    logic               wr;
    logic               interp;
    logic               rot;
    logic [IDX_W-1:0]   idx;
    logic [VAL_W-1:0]   wval;
    logic [FLD_W-1:0]   start;
    logic [BLEND_W-1:0] blend;
  } front_t;

  // Travels alongside the blend divider.
  typedef struct packed {
    logic             neg;
    logic [EXT_W-1:0] base;
  } back_t;

  // Request into the table stage.
  typedef struct packed {
    logic             vld;
    logic             wr;
    logic [IDX_W-1:0] idx0;
    logic [IDX_W-1:0] idx1;
    logic [VAL_W-1:0] wval;
  } tbl_req_t;

endpackage

FILE: hdl/keyframe_channel_sampler_unit.sv
// Channel   Direction  Handshake                Payload
// cfg       in         cfg_we_i                 cfg_wdata_i (entries_in_use)
// in        in         in_valid_i / in_ready_o  action, write and sample fields
// out       out        out_valid_o / out_ready_i sample_value_o
//
// One word is taken every cycle while the pipeline advances; a sample word
// passes the 16-stage frame divider, stages 1 to 6, the 41-stage blend divider,
// stage 7 and the output register. A write word reaches the table from stage 1.
// Reset clears the valid pipeline and entries_in_use; the table is not cleared.
// A result held on the output stalls the pipeline only when the stage behind
// it is full; bubbles still advance and new words are still taken.

`include "keyframe_channel_sampler_unit_assert.svh"

module keyframe_channel_sampler_unit
  import kcs_pkg::*;
#(
  parameter int TABLE_DEPTH = 4096,
  parameter int FRAC_BITS   = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CNT_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    action_i,
  input  logic [ADDR_W-1:0]       write_addr_i,
  input  logic signed [VAL_W-1:0] write_value_i,
  input  logic [FLD_W-1:0]        start_index_i,
  input  logic [BLEND_W-1:0]      step_blend_i,
  input  logic [FLD_W-1:0]        lut_length_i,
  input  logic [FLD_W-1:0]        frame_i,
  input  logic [FLD_W-1:0]        frame_total_i,
  input  logic                    is_rotation_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [VAL_W-1:0] sample_value_o
);

  // Pi in the table's fixed-point format, rounded from a 20-bit fraction.
  localparam int PiQ20   = 3294199;
  localparam int PiRound = (PiQ20 + (1 << (19 - FRAC_BITS))) >> (20 - FRAC_BITS);
  localparam logic signed [EXT_W-1:0] PiFix = EXT_W'(PiRound);
  localparam logic signed [EXT_W-1:0] TwoPi = EXT_W'(2 * PiRound);

  logic adv;

  // Configuration register.
  logic [CNT_W-1:0] entries_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= '0;
    end else if (cfg_we_i) begin
      entries_q <= cfg_wdata_i;
    end
  end

  // Front end: classify the word and work out the index for every case that
  // needs no division. The tail limit rounds T - 1 down to a multiple of
  // 2^(B >> 1); shifts of 16 or more clear it, so every frame is in the tail.
  front_t           front;
  logic [FLD_W-1:0] tail_lim;
  logic             is_tail;
  logic [IDX_W-1:0] idx_s;
  logic [IDX_W-1:0] tail_idx;

  always_comb begin
    tail_lim = (step_blend_i[BLEND_W-1:5] != '0) ? '0 :
               ((frame_total_i - FLD_W'(1)) & ({FLD_W{1'b1}} << step_blend_i[4:1]));
    is_tail  = (frame_total_i == '0) || (frame_i >= tail_lim);
    idx_s    = IDX_W'(start_index_i);
    tail_idx = idx_s + IDX_W'(lut_length_i) - IDX_W'(frame_total_i) + IDX_W'(frame_i);

    front        = '0;
    front.wr     = (action_i == ACT_WRITE);
    front.rot    = is_rotation_i;
    front.wval   = write_value_i;
    front.start  = start_index_i;
    front.blend  = step_blend_i;
    priority if (action_i == ACT_WRITE) begin
      front.idx = IDX_W'(write_addr_i);
    end else if (lut_length_i == FLD_W'(1) || step_blend_i == '0) begin
      front.idx = idx_s;
    end else if (step_blend_i == BLEND_W'(1)) begin
      front.idx = idx_s + IDX_W'(frame_i);
    end else if (is_tail) begin
      front.idx = tail_idx;
    end else begin
      front.interp = 1'b1;
    end
  end

  assign in_ready_o = adv;

  // Frame divider: q = F / B and r = F mod B.
  logic               d1_vld;
  logic [FLD_W-1:0]   d1_quot;
  logic [BLEND_W-1:0] d1_rem;
  front_t             d1_side;

  kcs_div #(
    .DW (FLD_W),
    .VW (BLEND_W),
    .SW ($bits(front_t))
  ) u_frame_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (in_valid_i),
    .dividend_i (frame_i),
    .divisor_i  (step_blend_i),
    .side_i     (front),
    .valid_o    (d1_vld),
    .quot_o     (d1_quot),
    .rem_o      (d1_rem),
    .side_o     (d1_side)
  );

  // Stage 1: table indices. Every read that is not a true blend is forced to
  // a zero fraction over a divisor of one, so the blend path returns entry a.
  logic               p1_vld_q;
  logic               p1_wr_q;
  logic [IDX_W-1:0]   p1_idx0_q, p1_idx0_d;
  logic [IDX_W-1:0]   p1_idx1_q, p1_idx1_d;
  logic [VAL_W-1:0]   p1_wval_q;
  logic [BLEND_W-1:0] p1_r_q, p1_r_d;
  logic [BLEND_W-1:0] p1_b_q, p1_b_d;
  logic               p1_rot_q, p1_rot_d;
  logic [IDX_W-1:0]   sq;
  logic               use_r;

  always_comb begin
    sq        = IDX_W'(d1_side.start) + IDX_W'(d1_quot);
    p1_idx0_d = d1_side.interp ? sq : d1_side.idx;
    p1_idx1_d = IDX_W'(d1_side.start) + IDX_W'(d1_quot) + IDX_W'(1);
    use_r     = d1_side.interp && (d1_rem != '0);
    p1_r_d    = use_r ? d1_rem : '0;
    p1_b_d    = use_r ? d1_side.blend : BLEND_W'(1);
    p1_rot_d  = use_r && d1_side.rot;
  end

  // Stage 2: table access.
  tbl_req_t                tbl_req;
  logic signed [VAL_W-1:0] rd0;
  logic signed [VAL_W-1:0] rd1;

  assign tbl_req = '{vld: p1_vld_q, wr: p1_wr_q, idx0: p1_idx0_q, idx1: p1_idx1_q,
                     wval: p1_wval_q};

  kcs_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .req_i     (tbl_req),
    .entries_i (entries_q),
    .rd0_o     (rd0),
    .rd1_o     (rd1)
  );

  logic               p2_vld_q;
  logic [BLEND_W-1:0] p2_r_q;
  logic [BLEND_W-1:0] p2_b_q;
  logic               p2_rot_q;

  // Stage 3: angle wrap for rotation channels. When a lies more than pi above b,
  // b moves up by 2*pi; when it lies more than pi below, a moves up instead.
  logic               p3_vld_q;
  logic [BLEND_W-1:0] p3_r_q;
  logic [BLEND_W-1:0] p3_b_q;
  logic signed [EXT_W-1:0] p3_a_q, p3_a_d;
  logic signed [EXT_W-1:0] p3_c_q, p3_c_d;
  logic signed [EXT_W-1:0] a_ext;
  logic signed [EXT_W-1:0] c_ext;
  logic signed [EXT_W-1:0] diff;

  always_comb begin
    a_ext  = EXT_W'(rd0);
    c_ext  = EXT_W'(rd1);
    diff   = a_ext - c_ext;
    p3_a_d = a_ext;
    p3_c_d = c_ext;
    priority if (p2_rot_q && (diff > PiFix)) begin
      p3_c_d = c_ext + TwoPi;
    end else if (p2_rot_q && (diff < -PiFix)) begin
      p3_a_d = a_ext + TwoPi;
    end else begin
      p3_a_d = a_ext;
    end
  end

  // Stage 4: difference b - a.
  logic               p4_vld_q;
  logic [BLEND_W-1:0] p4_r_q;
  logic [BLEND_W-1:0] p4_b_q;
  logic signed [EXT_W-1:0] p4_a_q;
  logic signed [DIF_W-1:0] p4_d_q;

  // Stage 5: sign and magnitude, so the blend division truncates toward zero.
  logic               p5_vld_q;
  logic [BLEND_W-1:0] p5_r_q;
  logic [BLEND_W-1:0] p5_b_q;
  logic signed [EXT_W-1:0] p5_a_q;
  logic               p5_neg_q;
  logic [MAG_W-1:0]   p5_mag_q;
  logic signed [DIF_W-1:0] mag_abs;

  assign mag_abs = p4_d_q[DIF_W-1] ? -p4_d_q : p4_d_q;

  // Stage 6: |b - a| * r.
  logic               p6_vld_q;
  logic [BLEND_W-1:0] p6_b_q;
  back_t              p6_side_q;
  logic [PROD_W-1:0]  p6_prod_q, p6_prod_d;

  assign p6_prod_d = {{BLEND_W{1'b0}}, p5_mag_q} * {{MAG_W{1'b0}}, p5_r_q};

  // Blend divider: |b - a| * r / B.
  logic              d2_vld;
  logic [PROD_W-1:0] d2_quot;
  back_t             d2_side;

  kcs_div #(
    .DW (PROD_W),
    .VW (BLEND_W),
    .SW ($bits(back_t))
  ) u_blend_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (p6_vld_q),
    .dividend_i (p6_prod_q),
    .divisor_i  (p6_b_q),
    .side_i     (p6_side_q),
    .valid_o    (d2_vld),
    .quot_o     (d2_quot),
    .rem_o      (),
    .side_o     (d2_side)
  );

  // Stage 7: restore the sign of the blend term.
  logic                    p7_vld_q;
  logic signed [EXT_W-1:0] p7_base_q;
  logic signed [SUM_W-1:0] p7_qs_q, p7_qs_d;
  logic signed [SUM_W-1:0] quot_ext;

  assign quot_ext = $signed({{(SUM_W - PROD_W){1'b0}}, d2_quot});
  assign p7_qs_d  = d2_side.neg ? -quot_ext : quot_ext;

  // Output register: a + blend term, saturated to 32 bits.
  logic                    out_vld_q;
  logic signed [VAL_W-1:0] out_val_q, out_val_d;
  logic signed [SUM_W-1:0] sum;

  always_comb begin
    sum = SUM_W'(p7_base_q) + p7_qs_q;
    if (sum[SUM_W-1:VAL_W-1] == {(SUM_W - VAL_W + 1){sum[SUM_W-1]}}) begin
      out_val_d = sum[VAL_W-1:0];
    end else if (sum[SUM_W-1]) begin
      out_val_d = {1'b1, {(VAL_W - 1){1'b0}}};
    end else begin
      out_val_d = {1'b0, {(VAL_W - 1){1'b1}}};
    end
  end

  // The pipeline moves unless a held result has a full stage behind it.
  assign adv = !out_vld_q || out_ready_i || !p7_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q  <= 1'b0;
      p1_wr_q   <= 1'b0;
      p2_vld_q  <= 1'b0;
      p3_vld_q  <= 1'b0;
      p4_vld_q  <= 1'b0;
      p5_vld_q  <= 1'b0;
      p6_vld_q  <= 1'b0;
      p7_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        p1_vld_q <= d1_vld;
        p1_wr_q  <= d1_side.wr;
        p2_vld_q <= p1_vld_q && !p1_wr_q;
        p3_vld_q <= p2_vld_q;
        p4_vld_q <= p3_vld_q;
        p5_vld_q <= p4_vld_q;
        p6_vld_q <= p5_vld_q;
        p7_vld_q <= d2_vld;
      end
      if (!out_vld_q || out_ready_i) begin
        out_vld_q <= p7_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_idx0_q      <= p1_idx0_d;
      p1_idx1_q      <= p1_idx1_d;
      p1_wval_q      <= d1_side.wval;
      p1_r_q         <= p1_r_d;
      p1_b_q         <= p1_b_d;
      p1_rot_q       <= p1_rot_d;
      p2_r_q         <= p1_r_q;
      p2_b_q         <= p1_b_q;
      p2_rot_q       <= p1_rot_q;
      p3_r_q         <= p2_r_q;
      p3_b_q         <= p2_b_q;
      p3_a_q         <= p3_a_d;
      p3_c_q         <= p3_c_d;
      p4_r_q         <= p3_r_q;
      p4_b_q         <= p3_b_q;
      p4_a_q         <= p3_a_q;
      p4_d_q         <= DIF_W'(p3_c_q) - DIF_W'(p3_a_q);
      p5_r_q         <= p4_r_q;
      p5_b_q         <= p4_b_q;
      p5_a_q         <= p4_a_q;
      p5_neg_q       <= p4_d_q[DIF_W-1];
      p5_mag_q       <= mag_abs[MAG_W-1:0];
      p6_b_q         <= p5_b_q;
      p6_side_q.neg  <= p5_neg_q;
      p6_side_q.base <= p5_a_q;
      p6_prod_q      <= p6_prod_d;
      p7_base_q      <= d2_side.base;
      p7_qs_q        <= p7_qs_d;
    end
    if (!out_vld_q || out_ready_i) begin
      out_val_q <= out_val_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign sample_value_o = out_val_q;

  // The blend fraction is below one, so the quotient never exceeds |b - a|.
  `KCS_ASSERT_NOW(a_blend_quot_bound, clk_i, rst_ni, d2_vld, d2_quot[PROD_W-1:MAG_W] == '0)
  // Direct reads carry a zero fraction into the blend divider.
  `KCS_ASSERT_NEXT(a_direct_zero_prod, clk_i, rst_ni, p5_vld_q && adv && p5_r_q == '0, p6_prod_q == '0)
  // A new result only ever comes from a filled last stage.
  `KCS_ASSERT_NOW(a_out_from_pipe, clk_i, rst_ni, $rose(out_vld_q), $past(p7_vld_q))

endmodule

FILE: hdl/kcs_div.sv
`include "keyframe_channel_sampler_unit_assert.svh"

// Pipelined restoring divider, one quotient bit per stage.
module kcs_div #(
  parameter int DW = 16,
  parameter int VW = 8,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [DW-1:0] quot_o,
  output logic [VW-1:0] rem_o,
  output logic [SW-1:0] side_o
);

  logic          vld_q  [DW];
  logic [DW-1:0] dvd_q  [DW];
  logic [DW-1:0] quo_q  [DW];
  logic [VW-1:0] rem_q  [DW];
  logic [VW-1:0] dvs_q  [DW];
  logic [SW-1:0] side_q [DW];

  for (genvar i = 0; i < DW; i++) begin : g_stage
    logic          vld_in;
    logic [DW-1:0] dvd_in;
    logic [DW-1:0] quo_in;
    logic [VW-1:0] rem_in;
    logic [VW-1:0] dvs_in;
    logic [SW-1:0] side_in;
    logic [VW:0]   trial;
    logic          fits;
    logic [VW-1:0] rem_d;
    logic [DW-1:0] quo_d;

    if (i == 0) begin : g_first
      assign vld_in  = valid_i;
      assign dvd_in  = dividend_i;
      assign quo_in  = '0;
      assign rem_in  = '0;
      assign dvs_in  = divisor_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign dvd_in  = dvd_q[i-1];
      assign quo_in  = quo_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign dvs_in  = dvs_q[i-1];
      assign side_in = side_q[i-1];
    end

    // Bring down the next dividend bit and subtract the divisor if it fits.
    assign trial = {rem_in, dvd_in[DW-1]};
    assign fits  = (trial >= {1'b0, dvs_in});
    assign rem_d = fits ? VW'(trial - {1'b0, dvs_in}) : trial[VW-1:0];
    assign quo_d = {quo_in[DW-2:0], fits};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dvd_q[i]  <= {dvd_in[DW-2:0], 1'b0};
        quo_q[i]  <= quo_d;
        rem_q[i]  <= rem_d;
        dvs_q[i]  <= dvs_in;
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[DW-1];
  assign quot_o  = quo_q[DW-1];
  assign rem_o   = rem_q[DW-1];
  assign side_o  = side_q[DW-1];

  `KCS_ASSERT_NOW(a_rem_below_divisor, clk_i, rst_ni, vld_q[DW-1] && dvs_q[DW-1] != '0, rem_q[DW-1] < dvs_q[DW-1])

endmodule

FILE: hdl/kcs_table.sv
// Keyframe store: one write port, two registered read ports.
module kcs_table
  import kcs_pkg::*;
#(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  tbl_req_t                req_i,
  input  logic [CNT_W-1:0]        entries_i,
  output logic signed [VAL_W-1:0] rd0_o,
  output logic signed [VAL_W-1:0] rd1_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic signed [IDX_W-1:0] DepthIdx = IDX_W'(TABLE_DEPTH);

  logic [VAL_W-1:0]        mem_q [TABLE_DEPTH];
  logic [VAL_W-1:0]        rdata0_q;
  logic [VAL_W-1:0]        rdata1_q;
  logic                    ok0_q;
  logic                    ok1_q;
  logic                    ok0_d;
  logic                    ok1_d;
  logic                    wr_ok;
  logic                    wr_active_q;
  logic signed [IDX_W-1:0] ent_s;

  function automatic logic in_range(logic [IDX_W-1:0] idx, logic signed [IDX_W-1:0] lim);
    logic signed [IDX_W-1:0] s;
    s = $signed(idx);
    return (s >= 0) && (s < lim) && (s < DepthIdx);
  endfunction

  assign ent_s = $signed(IDX_W'(entries_i));
  assign ok0_d = in_range(req_i.idx0, ent_s);
  assign ok1_d = in_range(req_i.idx1, ent_s);
  assign wr_ok = ($signed(req_i.idx0) < DepthIdx);

  // Items pass this stage in order, so a read always sees every earlier write.
  always_ff @(posedge clk_i) begin
    if (en_i && req_i.vld && req_i.wr && wr_ok) begin
      mem_q[req_i.idx0[AW-1:0]] <= req_i.wval;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata0_q <= mem_q[req_i.idx0[AW-1:0]];
      rdata1_q <= mem_q[req_i.idx1[AW-1:0]];
      ok0_q    <= ok0_d;
      ok1_q    <= ok1_d;
    end
  end

  // Tracks whether the last advancing item was a write; gates nothing
  // functional but keeps read masking honest for write slots.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_active_q <= 1'b0;
    end else if (en_i) begin
      wr_active_q <= req_i.vld && req_i.wr;
    end
  end

  assign rd0_o = (ok0_q && !wr_active_q) ? $signed(rdata0_q) : '0;
  assign rd1_o = (ok1_q && !wr_active_q) ? $signed(rdata1_q) : '0;

endmodule
